/* hdl/light_energy_color_blend_assert.svh */
// Assertion macros shared by the checker of the light energy color blend.
// Needs clk and rst in the scope where a macro is used.
`ifndef LIGHT_ENERGY_COLOR_BLEND_ASSERT_SVH
`define LIGHT_ENERGY_COLOR_BLEND_ASSERT_SVH

// consequent must hold in the cycle after the antecedent, outside reset
`define LECB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lecb: next-cycle check failed");

// same check, also active while reset is applied
`define LECB_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lecb: reset check failed");

`endif

/* hdl/lecb_pkg.sv */
// Package for the light energy color blend: widths, fixed-point constants,
// register map, controller/datapath command types. No dependencies.
`timescale 1ns / 1ps

package lecb_pkg;

  localparam int COLOR_W          = 24;
  localparam int CHAN_W           = 8;
  localparam int NUM_CH           = 3;
  localparam int CH_W             = 2;
  localparam int ENERGY_W         = 24;
  localparam int GAIN_W           = 16;
  localparam int AMB_W            = 24;
  localparam int SUM_W            = 40;
  localparam int TOTAL_W          = 32;
  localparam int ENERGY_FRAC_BITS = 16;
  localparam int GAIN_FRAC_BITS   = 14;
  localparam int WEIGHT_W         = ENERGY_FRAC_BITS + 1;
  localparam int PROD_W           = AMB_W + WEIGHT_W;
  localparam int MIX_W            = ((PROD_W > SUM_W + GAIN_FRAC_BITS) ?
                                     PROD_W : SUM_W + GAIN_FRAC_BITS) + 1;
  localparam int MIX_SHIFT        = GAIN_FRAC_BITS + ENERGY_FRAC_BITS;
  localparam int QUOT_W           = CHAN_W;
  localparam int STEP_W           = 3;

  localparam logic [WEIGHT_W-1:0] ENERGY_ONE = WEIGHT_W'(1) << ENERGY_FRAC_BITS;
  localparam logic [CHAN_W-1:0]   CH_MAX     = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;
  localparam logic [GAIN_W-1:0]   GAIN_RESET = 16'd16384;

  // APB register map
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_AMBIENT_GAIN = 1'b0;

  typedef struct packed {
    logic              latch_in;
    logic              acc;
    logic              prep;
    logic              div_step;
    logic              mix;
    logic              load_out;
    logic [CH_W-1:0]   chan;
    logic [STEP_W-1:0] step;
  } lecb_cmd_t;

  typedef struct packed {
    logic last;
    logic div_needed;
  } lecb_stat_t;

  // red sits in the top byte
  function automatic logic [CHAN_W-1:0] channel_of(input logic [COLOR_W-1:0] rgb,
                                                   input logic [CH_W-1:0] idx);
    logic [CHAN_W-1:0] c;
    case (idx)
      2'd0:    c = rgb[23:16];
      2'd1:    c = rgb[15:8];
      default: c = rgb[7:0];
    endcase
    return c;
  endfunction

endpackage

/* hdl/lecb_ctrl.sv */
// Controller of the light energy color blend: sequences accumulate, per-channel
// blend/divide steps and the output handshake. Uses lecb_pkg.
`timescale 1ns / 1ps

module lecb_ctrl
  import lecb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  lecb_stat_t stat,
  output lecb_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_PREP = 6'b000100,
    S_DIV  = 6'b001000,
    S_MIX  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t            state, state_next;
  logic [CH_W-1:0]   chan, chan_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;

  always_comb begin
    state_next     = state;
    chan_next      = chan;
    step_next      = step;
    out_valid_next = out_valid;
    cmd            = '0;
    cmd.chan       = chan;
    cmd.step       = step;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (stat.last) begin
          chan_next  = '0;
          state_next = S_PREP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        step_next  = STEP_W'(QUOT_W - 1);
        state_next = stat.div_needed ? S_DIV : S_MIX;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step == '0) begin
          state_next = S_MIX;
        end else begin
          step_next = step - 1'b1;
        end
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        if (chan == CH_W'(NUM_CH - 1)) begin
          state_next = S_OUT;
        end else begin
          chan_next  = chan + 1'b1;
          state_next = S_PREP;
        end
      end
      S_OUT: begin
        // wait until the output register is free
        if (!out_valid || out_ready) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chan      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chan      <= chan_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

/* hdl/lecb_datapath.sv */
// Datapath of the light energy color blend: input word latch, accumulators,
// ambient gain register, blend multiplier, restoring divider, output register.
// Uses lecb_pkg; driven by lecb_ctrl.
`timescale 1ns / 1ps

module lecb_datapath
  import lecb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  lecb_cmd_t           cmd,
  output lecb_stat_t          stat,
  input  logic                gain_we,
  input  logic [GAIN_W-1:0]   gain_wdata,
  output logic [GAIN_W-1:0]   gain,
  input  logic [COLOR_W-1:0]  surface_color,
  input  logic [COLOR_W-1:0]  light_color,
  input  logic [ENERGY_W-1:0] light_energy,
  input  logic                light_valid,
  input  logic                first_light,
  input  logic                last_light,
  output logic [COLOR_W-1:0]  pixel_color
);

  logic [COLOR_W-1:0]  surface_r, light_r;
  logic [ENERGY_W-1:0] energy_r;
  logic                valid_r, first_r, last_r;

  logic [AMB_W-1:0]    amb   [NUM_CH];
  logic [SUM_W-1:0]    wsum  [NUM_CH];
  logic [SUM_W-1:0]    wsum_next [NUM_CH];
  logic [TOTAL_W-1:0]  etot, etot_next;

  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    rem_r;
  logic [QUOT_W-1:0]   quot_r;
  logic                clamp_r;
  logic [CHAN_W-1:0]   res_ch [NUM_CH];

  logic [SUM_W-1:0]    w_sel;
  logic [AMB_W-1:0]    a_sel;
  logic                big;
  logic                over;
  logic [WEIGHT_W-1:0] weight;
  logic [SUM_W-1:0]    dsor;
  logic                fits;
  logic [MIX_W-1:0]    mix_sum, mix_shr;
  logic [CHAN_W-1:0]   mix_val, ch_val;

  // latch the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      surface_r <= surface_color;
      light_r   <= light_color;
      energy_r  <= light_energy;
      valid_r   <= light_valid;
      first_r   <= first_light;
      last_r    <= last_light;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (gain_we) begin
      gain <= gain_wdata;
    end
  end

  // accumulate: clear on first word, add the light if valid, saturate
  always_comb begin
    logic [TOTAL_W-1:0] tbase;
    logic [TOTAL_W:0]   tsum;
    tbase = first_r ? '0 : etot;
    tsum  = {1'b0, tbase} + (TOTAL_W + 1)'(energy_r);
    if (!valid_r) begin
      etot_next = tbase;
    end else if (tsum[TOTAL_W]) begin
      etot_next = TOTAL_MAX;
    end else begin
      etot_next = tsum[TOTAL_W-1:0];
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [SUM_W-1:0]           wbase;
    logic [CHAN_W+ENERGY_W-1:0] wprod;
    logic [SUM_W:0]             wadd;
    always_comb begin
      wbase = first_r ? '0 : wsum[c];
      wprod = (CHAN_W + ENERGY_W)'(channel_of(light_r, CH_W'(c)))
            * (CHAN_W + ENERGY_W)'(energy_r);
      wadd  = {1'b0, wbase} + (SUM_W + 1)'(wprod);
      if (!valid_r) begin
        wsum_next[c] = wbase;
      end else if (wadd[SUM_W]) begin
        wsum_next[c] = SUM_MAX;
      end else begin
        wsum_next[c] = wadd[SUM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        amb[c]  <= '0;
        wsum[c] <= '0;
      end else if (cmd.acc) begin
        if (first_r) begin
          amb[c] <= AMB_W'(channel_of(surface_r, CH_W'(c))) * AMB_W'(gain);
        end
        wsum[c] <= wsum_next[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      etot <= '0;
    end else if (cmd.acc) begin
      etot <= etot_next;
    end
  end

  // per-channel blend
  assign w_sel  = wsum[cmd.chan];
  assign a_sel  = amb[cmd.chan];
  assign big    = (etot >= TOTAL_W'(ENERGY_ONE));
  assign over   = (w_sel >= {etot, {(SUM_W - TOTAL_W){1'b0}}});
  assign weight = ENERGY_ONE - etot[WEIGHT_W-1:0];

  assign stat.last       = last_r;
  assign stat.div_needed = big && !over;

  assign dsor = SUM_W'(etot) << cmd.step;
  assign fits = (rem_r >= dsor);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      prod_r  <= PROD_W'(a_sel) * PROD_W'(weight);
      rem_r   <= w_sel;
      quot_r  <= '0;
      clamp_r <= over;
    end else if (cmd.div_step) begin
      // one quotient bit per cycle
      if (fits) begin
        rem_r <= rem_r - dsor;
      end
      quot_r <= {quot_r[QUOT_W-2:0], fits};
    end
  end

  assign mix_sum = MIX_W'(prod_r) + (MIX_W'(w_sel) << GAIN_FRAC_BITS);
  assign mix_shr = mix_sum >> MIX_SHIFT;
  assign mix_val = (mix_shr > MIX_W'(CH_MAX)) ? CH_MAX : mix_shr[CHAN_W-1:0];

  always_comb begin
    if (!big) begin
      ch_val = mix_val;
    end else if (clamp_r) begin
      ch_val = CH_MAX;
    end else begin
      ch_val = quot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mix) begin
      res_ch[cmd.chan] <= ch_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pixel_color <= {res_ch[0], res_ch[1], res_ch[2]};
    end
  end

endmodule

/* hdl/light_energy_color_blend.sv */
// Light energy color blend, top level: the APB register port, the controller
// and the datapath. Uses lecb_pkg, lecb_ctrl and lecb_datapath.
//
// Usage: one input word per light of a pixel on the in_valid/in_ready channel;
// first_light opens a pixel (clears the sums, latches the ambient color from
// surface_color), last_light closes it. Each closing word yields one
// pixel_color word on the out_valid/out_ready channel.
// Each word that is not last is latched, then accumulated; a closing word
// is accumulated, then each channel is prepared and blended, with restoring
// divider steps (one quotient bit per cycle) between the two unless the
// total energy is below 1.0 or the quotient saturates; last the output
// register is loaded and out_valid rises. New words are taken only in idle.
// The next pixel's words are taken while a result waits in the output
// register; a stalled receiver holds the block only when the following
// result is ready to load.
// Reset (synchronous, rst) empties the output, clears the accumulators and
// sets ambient_gain to 1.0 (Q2.14). ambient_gain is at APB address 0.
`timescale 1ns / 1ps

module light_energy_color_blend
  import lecb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COLOR_W-1:0]  surface_color,
  input  logic [COLOR_W-1:0]  light_color,
  input  logic [ENERGY_W-1:0] light_energy,
  input  logic                light_valid,
  input  logic                first_light,
  input  logic                last_light,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOR_W-1:0]  pixel_color
);

  lecb_cmd_t         cmd;
  lecb_stat_t        stat;
  logic              gain_sel;
  logic              gain_we;
  logic [GAIN_W-1:0] gain;

  assign pready   = 1'b1;
  assign gain_sel = (paddr[REG_IDX_LSB] == REG_AMBIENT_GAIN);
  assign gain_we  = psel && penable && pwrite && gain_sel;
  assign prdata   = gain_sel ? DATA_W'(gain) : '0;

  lecb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lecb_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .gain_we       (gain_we),
    .gain_wdata    (pwdata[GAIN_W-1:0]),
    .gain          (gain),
    .surface_color (surface_color),
    .light_color   (light_color),
    .light_energy  (light_energy),
    .light_valid   (light_valid),
    .first_light   (first_light),
    .last_light    (last_light),
    .pixel_color   (pixel_color)
  );

endmodule

/* hdl/lecb_checker.sv */
// Port-level checks for the light energy color blend, bound to the top level.
// Uses lecb_pkg and light_energy_color_blend_assert.svh.
`timescale 1ns / 1ps
`include "light_energy_color_blend_assert.svh"

module lecb_checker
  import lecb_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               last_light,
  input logic               out_valid,
  input logic               out_ready,
  input logic [COLOR_W-1:0] pixel_color
);

  `LECB_ASSERT_NEXT_ALWAYS(a_rst_empty, rst, !out_valid)
  `LECB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_color))
  `LECB_ASSERT_NEXT(a_word_busy, in_valid && in_ready, !in_ready)
  `LECB_ASSERT_NEXT(a_last_no_out, in_valid && in_ready && last_light, !$rose(out_valid))

endmodule

bind light_energy_color_blend lecb_checker u_lecb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_light  (last_light),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pixel_color (pixel_color)
);

/* tb/tb_light_energy_color_blend.sv */
// Self-checking testbench for light_energy_color_blend: directed and random
// light words, with a built-in predictor and an in-order pixel color checker.
// Depends on lecb_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_light_energy_color_blend;
  import lecb_pkg::*;

  localparam int          DRAIN_CYCLES = 40;
  localparam int          STALL_LIMIT  = 5000;
  localparam int unsigned GAIN_IDX     = REG_AMBIENT_GAIN;
  localparam int unsigned SPARE_IDX    = 1;
  localparam logic [ADDR_W-1:0] GAIN_ADDR  = ADDR_W'(GAIN_IDX << REG_IDX_LSB);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(SPARE_IDX << REG_IDX_LSB);
  localparam logic [63:0] ENERGY_UNITY = 64'd1 << ENERGY_FRAC_BITS;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel, penable, pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata, prdata;
  logic                pready;
  logic                in_valid, in_ready;
  logic [COLOR_W-1:0]  surface_color, light_color;
  logic [ENERGY_W-1:0] light_energy;
  logic                light_valid, first_light, last_light;
  logic                out_valid, out_ready;
  logic [COLOR_W-1:0]  pixel_color;

  // shadow state of the blend
  logic [GAIN_W-1:0]   shade_gain = GAIN_RESET;
  logic [AMB_W-1:0]    shade_ambient [NUM_CH] = '{default: '0};
  logic [SUM_W-1:0]    shade_sums [NUM_CH] = '{default: '0};
  logic [TOTAL_W-1:0]  shade_energy = '0;
  logic [COLOR_W-1:0]  pixel_colors_due [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int words_sent = 0;
  int pixels_checked = 0;
  int quiet_cycles = 0;

  light_energy_color_blend dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) out_ready = ($urandom_range(99) >= recv_stall_pct);

  function automatic logic [CHAN_W-1:0] blended_channel(input int c);
    logic [63:0] amb, sum, tot, mix;
    amb = 64'(shade_ambient[c]);
    sum = 64'(shade_sums[c]);
    tot = 64'(shade_energy);
    if (tot >= ENERGY_UNITY) begin
      mix = sum / tot;
    end else begin
      mix = (amb * (ENERGY_UNITY - tot) + (sum << GAIN_FRAC_BITS))
            >> (GAIN_FRAC_BITS + ENERGY_FRAC_BITS);
    end
    return (mix > 64'd255) ? CH_MAX : mix[CHAN_W-1:0];
  endfunction

  function automatic void take_light_word(input logic [COLOR_W-1:0] surf, light,
                                          input logic [ENERGY_W-1:0] energy,
                                          input logic valid, open, close);
    logic [TOTAL_W:0] tot_next;
    logic [SUM_W:0]   sum_next;
    if (open) begin
      for (int c = 0; c < NUM_CH; c++) begin
        shade_ambient[c] = AMB_W'(32'(surf[(2 - c) * 8 +: 8]) * 32'(shade_gain));
        shade_sums[c] = '0;
      end
      shade_energy = '0;
    end
    if (valid) begin
      tot_next = {1'b0, shade_energy} + (TOTAL_W + 1)'(energy);
      shade_energy = tot_next[TOTAL_W] ? TOTAL_MAX : tot_next[TOTAL_W-1:0];
      for (int c = 0; c < NUM_CH; c++) begin
        sum_next = {1'b0, shade_sums[c]}
                 + (SUM_W + 1)'(light[(2 - c) * 8 +: 8]) * (SUM_W + 1)'(energy);
        shade_sums[c] = sum_next[SUM_W] ? SUM_MAX : sum_next[SUM_W-1:0];
      end
    end
    if (close) begin
      pixel_colors_due.push_back({blended_channel(0), blended_channel(1), blended_channel(2)});
    end
  endfunction

  // check results first: nothing accepted this edge can already be at the output
  always @(posedge clk) begin : monitor
    logic [COLOR_W-1:0] want;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_colors_due.size() == 0) begin
          $error("pixel_color: word with nothing expected, actual %06h", pixel_color);
          fail_count++;
        end else begin
          want = pixel_colors_due.pop_front();
          pixels_checked++;
          if (pixel_color !== want) begin
            $error("pixel_color mismatch: expected %06h, actual %06h", want, pixel_color);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        take_light_word(surface_color, light_color, light_energy,
                        light_valid, first_light, last_light);
        words_sent++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer", quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [COLOR_W-1:0] surf, light,
                           input logic [ENERGY_W-1:0] energy,
                           input logic valid, open, close);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    surface_color = surf;
    light_color   = light;
    light_energy  = energy;
    light_valid   = valid;
    first_light   = open;
    last_light    = close;
    in_valid      = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid, drain the results, then let the divider settle
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_colors_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((addr >> REG_IDX_LSB) == GAIN_IDX) shade_gain = data[GAIN_W-1:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic reg_check(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = addr;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("prdata mismatch: expected %08h, actual %08h", want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] gain);
    wait_idle();
    reg_write(GAIN_ADDR, DATA_W'(gain));
    reg_check(GAIN_ADDR, DATA_W'(gain));
  endtask

  function automatic logic [ENERGY_W-1:0] pick_energy(input int mode, input int lights);
    case (mode)
      0:       return ENERGY_W'($urandom_range(0, 65535 / lights));
      1:       return ENERGY_W'($urandom());
      2:       return ENERGY_W'($urandom_range(0, 32'h3FFFF));
      default: return '0;
    endcase
  endfunction

  task automatic test_reset_value();
    reg_check(GAIN_ADDR, DATA_W'(GAIN_RESET));
  endtask

  // words before any opening word build on the zeroed state
  task automatic test_no_open_after_reset();
    send_word(24'hFFFFFF, 24'h804020, 24'h008000, 1'b1, 1'b0, 1'b0);
    send_word(24'h000000, 24'h10F0AA, 24'h004000, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_directed_corners();
    send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
    send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b1, 1'b1);
    send_word(24'h123456, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1, 1'b1);
    send_word(24'hA0B0C0, 24'h00FF80, 24'h00FFFF, 1'b1, 1'b1, 1'b1);
    send_word(24'hA0B0C0, 24'h00FF80, 24'h010000, 1'b1, 1'b1, 1'b1);
    // invalid word in the middle adds nothing
    send_word(24'h406080, 24'hFF0000, 24'h004000, 1'b1, 1'b1, 1'b0);
    send_word(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b0);
    send_word(24'h000000, 24'h0000FF, 24'h006000, 1'b1, 1'b0, 1'b1);
    // emitting leaves the sums in place
    send_word(24'hFFFFFF, 24'h00FF00, 24'h002000, 1'b1, 1'b0, 1'b1);
    send_word(24'h000000, 24'h000000, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
    send_word(24'h000000, 24'h000000, 24'h000000, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_gain_extremes();
    set_gain(16'hFFFF);
    send_word(24'hFFFFFF, 24'h000000, 24'h000000, 1'b0, 1'b1, 1'b1);
    send_word(24'h7F80FF, 24'h204060, 24'h000100, 1'b1, 1'b1, 1'b1);
    set_gain(16'h0000);
    send_word(24'hFFFFFF, 24'hFFFFFF, 24'h008000, 1'b1, 1'b1, 1'b1);
    send_word(24'hFFFFFF, 24'hFFFFFF, 24'h008000, 1'b0, 1'b1, 1'b1);
    // writes off the register map are dropped
    wait_idle();
    reg_write(SPARE_ADDR, 32'h0000FFFF);
    reg_check(GAIN_ADDR, 32'h00000000);
    set_gain(GAIN_RESET);
  endtask

  task automatic test_accumulator_saturation();
    send_idle_pct = 11;
    recv_stall_pct = 11;
    for (int i = 0; i < 260; i++) begin
      send_word(24'h3C5A78, 24'hFFFFFF, 24'hFFFFFF, 1'b1, i == 0, i == 259);
    end
    send_word(24'h000000, 24'h808080, 24'hFFFFFF, 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_random_pixels(input logic [GAIN_W-1:0] gain, input int idle_pct,
                                    input int stall_pct, input int word_count);
    int sent, lights, mode, pick;
    logic [COLOR_W-1:0] surf;
    set_gain(gain);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < word_count) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        lights = ($urandom_range(9) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 5);
        mode = $urandom_range(9);
        mode = (mode < 4) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
        surf = COLOR_W'($urandom());
        for (int i = 0; i < lights; i++) begin
          // now and then leave a pixel open so the next one runs into it
          send_word(surf, COLOR_W'($urandom()), pick_energy(mode, lights),
                    $urandom_range(9) != 0, i == 0,
                    (i == lights - 1) && (pick >= 4));
          surf = COLOR_W'($urandom());
        end
        sent += lights;
      end else begin
        send_word(COLOR_W'($urandom()), COLOR_W'($urandom()),
                  pick_energy($urandom_range(2), 4),
                  1'($urandom()), 1'($urandom()), 1'($urandom()));
        sent++;
      end
    end
  endtask

  initial begin
    logic [GAIN_W-1:0] mixed_gain;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; surface_color = '0; light_color = '0; light_energy = '0;
    light_valid = 1'b0; first_light = 1'b0; last_light = 1'b0;
    out_ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_value();
    test_no_open_after_reset();
    test_directed_corners();
    test_gain_extremes();
    test_accumulator_saturation();
    test_random_pixels(GAIN_RESET, 0, 0, 230);
    test_random_pixels(16'h0000, 73, 0, 230);
    test_random_pixels(16'hFFFF, 0, 73, 230);
    mixed_gain = GAIN_W'($urandom());
    test_random_pixels(mixed_gain, 11, 11, 230);
    mixed_gain = GAIN_W'($urandom());
    test_random_pixels(mixed_gain, 0, 0, 230);
    wait_idle();

    $display("Sent %0d light words, checked %0d pixel colors", words_sent, pixels_checked);
    $display("Gains 0, 1.0, max and random; idle and stall mixes on both channels");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/lecb_pkg.sv
hdl/lecb_ctrl.sv
hdl/lecb_datapath.sv
hdl/light_energy_color_blend.sv
hdl/lecb_checker.sv
tb/tb_light_energy_color_blend.sv
